// ===== rtl/core/m3i_pkg.sv =====
// Shared types, cofactor index tables and saturation limits for the 3x3 inverse core.
`timescale 1ns / 1ps
package m3i_pkg;

    localparam int ELEMS  = 9;
    localparam int DATA_W = 32;
    localparam int COF_W  = 64;
    localparam int DET_W  = 98;
    localparam int MAG_W  = 97;
    localparam int QUO_W  = 32;

    // Cofactor i is a[P]*a[Q] - a[R]*a[S], negated where COF_NEG is set
    localparam int COF_P [ELEMS] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
    localparam int COF_Q [ELEMS] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
    localparam int COF_R [ELEMS] = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
    localparam int COF_S [ELEMS] = '{7, 7, 4, 6, 6, 3, 6, 6, 3};
    localparam logic [ELEMS-1:0] COF_NEG = 9'b010101010;

    localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef logic [DATA_W-1:0] t_elem;

    typedef struct packed {
        logic vld;
        logic sing;
    } t_ctl;

endpackage

// ===== rtl/core/m3i_front.sv =====
// Front pipeline: cofactors, determinant, magnitudes and divider operands.
`timescale 1ns / 1ps
module m3i_front #(
    parameter int FRAC_BITS = 16,
    localparam int SHIFT = 2 * FRAC_BITS + 1,
    localparam int NUM_W = ((64 + SHIFT) > 97 ? (64 + SHIFT) : 97) + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  m3i_pkg::t_elem       i_a    [m3i_pkg::ELEMS],
    output m3i_pkg::t_ctl        o_ctl,
    output logic [NUM_W-1:0]     o_num  [m3i_pkg::ELEMS],
    output logic [m3i_pkg::ELEMS-1:0] o_neg,
    output logic [m3i_pkg::DET_W-1:0] o_twod
);
    import m3i_pkg::*;

    logic [6:0] r_vld;

    logic signed [COF_W-1:0] r1_pp [ELEMS];
    logic signed [COF_W-1:0] r1_pr [ELEMS];
    t_elem                   r1_a  [ELEMS];

    logic signed [COF_W-1:0] r2_adj [ELEMS];
    t_elem                   r2_a   [ELEMS];

    logic signed [63:0]      r3_hi [3];
    logic signed [64:0]      r3_lo [3];
    logic [COF_W-1:0]        r3_mag [ELEMS];
    logic [ELEMS-1:0]        r3_aneg;
    t_elem                   r3_a   [ELEMS];

    logic signed [MAG_W-1:0] r4_t [3];
    logic [COF_W-1:0]        r4_mag [ELEMS];
    logic [ELEMS-1:0]        r4_aneg;
    t_elem                   r4_a   [ELEMS];

    logic signed [DET_W-1:0] r5_det;
    logic [COF_W-1:0]        r5_mag [ELEMS];
    logic [ELEMS-1:0]        r5_aneg;
    t_elem                   r5_a   [ELEMS];

    logic                    r6_zero;
    logic                    r6_dneg;
    logic [MAG_W-1:0]        r6_dmag;
    logic [COF_W-1:0]        r6_mag [ELEMS];
    logic [ELEMS-1:0]        r6_aneg;
    t_elem                   r6_a   [ELEMS];

    logic                    r7_sing;
    logic [NUM_W-1:0]        r7_num [ELEMS];
    logic [ELEMS-1:0]        r7_neg;
    logic [DET_W-1:0]        r7_twod;

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_valid};
        end
    end

    // Stage 1: cofactor products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < ELEMS; i++) begin
                r1_pp[i] <= $signed(i_a[COF_P[i]]) * $signed(i_a[COF_Q[i]]);
                r1_pr[i] <= $signed(i_a[COF_R[i]]) * $signed(i_a[COF_S[i]]);
                r1_a[i]  <= i_a[i];
            end
        end
    end

    // Stage 2: signed cofactors, wrapping at 64 bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < ELEMS; i++) begin
                if (COF_NEG[i]) begin
                    r2_adj[i] <= r1_pr[i] - r1_pp[i];
                end else begin
                    r2_adj[i] <= r1_pp[i] - r1_pr[i];
                end
                r2_a[i] <= r1_a[i];
            end
        end
    end

    // Stage 3: determinant partial products along row 0, cofactor magnitudes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r3_hi[k] <= $signed(r2_a[k]) * $signed(r2_adj[3*k][63:32]);
                r3_lo[k] <= $signed(r2_a[k]) * $signed({1'b0, r2_adj[3*k][31:0]});
            end
            for (int i = 0; i < ELEMS; i++) begin
                r3_mag[i]  <= r2_adj[i][63] ? COF_W'(-r2_adj[i]) : COF_W'(r2_adj[i]);
                r3_aneg[i] <= r2_adj[i][63];
                r3_a[i]    <= r2_a[i];
            end
        end
    end

    // Stage 4: join the high and low halves of each term
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r4_t[k] <= $signed({r3_hi[k][63], r3_hi[k], 32'b0}) + MAG_W'(r3_lo[k]);
            end
            r4_mag  <= r3_mag;
            r4_aneg <= r3_aneg;
            r4_a    <= r3_a;
        end
    end

    // Stage 5: sum the three terms into the determinant
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_det  <= DET_W'(r4_t[0]) + DET_W'(r4_t[1]) + DET_W'(r4_t[2]);
            r5_mag  <= r4_mag;
            r5_aneg <= r4_aneg;
            r5_a    <= r4_a;
        end
    end

    // Stage 6: determinant sign, magnitude and zero test
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_zero <= (r5_det == '0);
            r6_dneg <= r5_det[DET_W-1];
            r6_dmag <= r5_det[DET_W-1] ? MAG_W'(-r5_det) : MAG_W'(r5_det);
            r6_mag  <= r5_mag;
            r6_aneg <= r5_aneg;
            r6_a    <= r5_a;
        end
    end

    // Stage 7: rounded numerators; a singular matrix rides in the numerator slot
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_sing <= r6_zero;
            r7_twod <= {r6_dmag, 1'b0};
            for (int i = 0; i < ELEMS; i++) begin
                if (r6_zero) begin
                    r7_num[i] <= {{(NUM_W-DATA_W){1'b0}}, r6_a[i]};
                end else begin
                    r7_num[i] <= (NUM_W'(r6_mag[i]) << SHIFT) + NUM_W'(r6_dmag);
                end
                r7_neg[i] <= r6_aneg[i] ^ r6_dneg;
            end
        end
    end

    assign o_ctl.vld  = r_vld[6];
    assign o_ctl.sing = r7_sing;
    assign o_num      = r7_num;
    assign o_neg      = r7_neg;
    assign o_twod     = r7_twod;

endmodule

// ===== rtl/core/m3i_div.sv =====
// Pipelined restoring divider, nine lanes, an overflow stage then one quotient bit per stage, plus output clamp.
`timescale 1ns / 1ps
module m3i_div #(
    parameter int FRAC_BITS = 16,
    localparam int SHIFT = 2 * FRAC_BITS + 1,
    localparam int NUM_W = ((64 + SHIFT) > 97 ? (64 + SHIFT) : 97) + 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  m3i_pkg::t_ctl             i_ctl,
    input  logic [NUM_W-1:0]          i_num [m3i_pkg::ELEMS],
    input  logic [m3i_pkg::ELEMS-1:0] i_neg,
    input  logic [m3i_pkg::DET_W-1:0] i_twod,
    output logic                      o_valid,
    output m3i_pkg::t_elem            o_b [m3i_pkg::ELEMS],
    output logic                      o_singular,
    output logic                      o_saturated
);
    import m3i_pkg::*;

    localparam int REM_W = (NUM_W > DET_W + QUO_W) ? NUM_W : DET_W + QUO_W;
    localparam int NSTEP = QUO_W + 1;

    logic [NSTEP-1:0]  r_vld;
    logic              r_sing [NSTEP];
    logic [ELEMS-1:0]  r_ovf  [NSTEP];
    logic [ELEMS-1:0]  r_neg  [NSTEP];
    logic [DET_W-1:0]  r_twod [NSTEP];
    logic [REM_W-1:0]  r_rem  [NSTEP][ELEMS];
    logic [QUO_W-1:0]  r_q    [NSTEP][ELEMS];

    t_elem             n_b [ELEMS];
    logic [ELEMS-1:0]  n_sat;
    logic              r_vld_o;
    t_elem             r_b [ELEMS];
    logic              r_sing_o;
    logic              r_sat_o;

    // Advance valid bits through the divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_vld_o <= 1'b0;
        end else if (i_en) begin
            r_vld   <= {r_vld[NSTEP-2:0], i_ctl.vld};
            r_vld_o <= r_vld[NSTEP-1];
        end
    end

    // First stage: catch quotients of 2^32 or more
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sing[0] <= i_ctl.sing;
            r_neg[0]  <= i_neg;
            r_twod[0] <= i_twod;
            for (int i = 0; i < ELEMS; i++) begin
                r_rem[0][i] <= REM_W'(i_num[i]);
                r_q[0][i]   <= '0;
                r_ovf[0][i] <= !i_ctl.sing &&
                               (REM_W'(i_num[i]) >= (REM_W'(i_twod) << QUO_W));
            end
        end
    end

    // Remaining stages: one trial subtract per lane each
    for (genvar j = 1; j < NSTEP; j++) begin : g_step
        localparam int B = QUO_W - j;
        logic [REM_W-1:0] trial;
        logic [ELEMS-1:0] take;

        assign trial = REM_W'(r_twod[j-1]) << B;

        always_comb begin
            for (int i = 0; i < ELEMS; i++) begin
                take[i] = !r_sing[j-1] && !r_ovf[j-1][i] && (r_rem[j-1][i] >= trial);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sing[j] <= r_sing[j-1];
                r_ovf[j]  <= r_ovf[j-1];
                r_neg[j]  <= r_neg[j-1];
                r_twod[j] <= r_twod[j-1];
                for (int i = 0; i < ELEMS; i++) begin
                    r_rem[j][i] <= take[i] ? r_rem[j-1][i] - trial : r_rem[j-1][i];
                    r_q[j][i]   <= r_q[j-1][i] | (QUO_W'(take[i]) << B);
                end
            end
        end
    end

    // Clamp to range and apply the sign, or pass the input through
    always_comb begin
        for (int i = 0; i < ELEMS; i++) begin
            n_sat[i] = 1'b0;
            if (r_sing[NSTEP-1]) begin
                n_b[i] = r_rem[NSTEP-1][i][DATA_W-1:0];
            end else if (r_neg[NSTEP-1][i]) begin
                if (r_ovf[NSTEP-1][i] || (r_q[NSTEP-1][i] > SAT_NEG)) begin
                    n_b[i]   = SAT_NEG;
                    n_sat[i] = 1'b1;
                end else begin
                    n_b[i] = -r_q[NSTEP-1][i];
                end
            end else begin
                if (r_ovf[NSTEP-1][i] || (r_q[NSTEP-1][i] > SAT_POS)) begin
                    n_b[i]   = SAT_POS;
                    n_sat[i] = 1'b1;
                end else begin
                    n_b[i] = r_q[NSTEP-1][i];
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b      <= n_b;
            r_sing_o <= r_sing[NSTEP-1];
            r_sat_o  <= |n_sat;
        end
    end

    assign o_valid     = r_vld_o;
    assign o_b         = r_b;
    assign o_singular  = r_sing_o;
    assign o_saturated = r_sat_o;

endmodule

// ===== rtl/core/matrix3x3_inverse_core.sv =====
// Top level of the 3x3 fixed-point matrix inverse core.
//
//  channel | direction | handshake           | words
//  --------+-----------+---------------------+-------------------------------------
//  input   | in        | i_valid / o_stall   | i_a00..i_a22
//  output  | out       | o_valid / i_stall   | o_b00..o_b22, o_singular, o_saturated
//
// One word enters per cycle while o_stall is low. Stages: seven cofactor and determinant
// stages, 33 divider stages (an overflow check, then one quotient bit each) and the output register.
// Reset is synchronous and clears only the valid bits along the pipeline.
// A stalled output word freezes the whole pipeline, so o_stall follows i_stall
// while a word waits at the output; nothing is dropped or repeated.
`timescale 1ns / 1ps
module matrix3x3_inverse_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_a00,
    input  logic [31:0] i_a01,
    input  logic [31:0] i_a02,
    input  logic [31:0] i_a10,
    input  logic [31:0] i_a11,
    input  logic [31:0] i_a12,
    input  logic [31:0] i_a20,
    input  logic [31:0] i_a21,
    input  logic [31:0] i_a22,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_b00,
    output logic [31:0] o_b01,
    output logic [31:0] o_b02,
    output logic [31:0] o_b10,
    output logic [31:0] o_b11,
    output logic [31:0] o_b12,
    output logic [31:0] o_b20,
    output logic [31:0] o_b21,
    output logic [31:0] o_b22,
    output logic        o_singular,
    output logic        o_saturated
);
    import m3i_pkg::*;

    localparam int SHIFT = 2 * FRAC_BITS + 1;
    localparam int NUM_W = ((64 + SHIFT) > 97 ? (64 + SHIFT) : 97) + 1;

    logic             en;
    t_elem            a [ELEMS];
    t_elem            b [ELEMS];
    t_ctl             fr_ctl;
    logic [NUM_W-1:0] fr_num [ELEMS];
    logic [ELEMS-1:0] fr_neg;
    logic [DET_W-1:0] fr_twod;

    // Hold the pipeline while the output word is not taken
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    assign a = '{i_a00, i_a01, i_a02, i_a10, i_a11, i_a12, i_a20, i_a21, i_a22};

    m3i_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_a     (a),
        .o_ctl   (fr_ctl),
        .o_num   (fr_num),
        .o_neg   (fr_neg),
        .o_twod  (fr_twod)
    );

    m3i_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_ctl       (fr_ctl),
        .i_num       (fr_num),
        .i_neg       (fr_neg),
        .i_twod      (fr_twod),
        .o_valid     (o_valid),
        .o_b         (b),
        .o_singular  (o_singular),
        .o_saturated (o_saturated)
    );

    assign o_b00 = b[0];
    assign o_b01 = b[1];
    assign o_b02 = b[2];
    assign o_b10 = b[3];
    assign o_b11 = b[4];
    assign o_b12 = b[5];
    assign o_b20 = b[6];
    assign o_b21 = b[7];
    assign o_b22 = b[8];

endmodule

// ===== rtl/core/m3i_checker.sv =====
// Port-level checks for the 3x3 inverse core, bound to the top level.
`timescale 1ns / 1ps
module m3i_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_b00,
    input logic        o_singular,
    input logic        o_saturated
);

    // Input stalls only while an output word waits
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a waiting output word");

    // A passed-through matrix never reports clamping
    a_sing_nosat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> !o_saturated)
        else $error("singular word flagged as saturated");

    // A stalled output word stays
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("output word dropped under stall");

    // A stalled output word keeps its value
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_b00) && $stable(o_singular)))
        else $error("output word changed under stall");

endmodule

bind matrix3x3_inverse_core m3i_checker u_m3i_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_b00       (o_b00),
    .o_singular  (o_singular),
    .o_saturated (o_saturated)
);
